### sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and byte functions of the aes block cipher
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUND_KEY_WORDS_DEF = 60;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_KSIZE = 3'd4;

    localparam logic [7:0] POLY_LOW = 8'h1B;
    localparam logic [7:0] BYTE_TOP = 8'h80;

    typedef struct packed {
        logic load;       // load block, first key addition
        logic rnd;        // run one round
        logic last;       // round without mix columns
        logic dec;        // inverse cipher
        logic kx_load;    // start key expansion, copy key words
        logic kx_step;    // one expansion word
    } aes_cmd_t;

    typedef struct packed {
        logic kx_done;
    } aes_stat_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    // inverse substitution table
    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return ((a & BYTE_TOP) != 8'd0) ? ({a[6:0], 1'b0} ^ POLY_LOW) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

### sv/aes_datapath.sv
// ----------------------------------------------------------------------------
// aes_datapath
// state register, round logic, key expansion and round key store
// ----------------------------------------------------------------------------
module aes_datapath #(
    parameter int ROUND_KEY_WORDS = aes_pkg::ROUND_KEY_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  aes_pkg::aes_cmd_t   cmd,
    output aes_pkg::aes_stat_t  stat,
    input  logic [255:0]        key,
    input  logic [1:0]          nk_sel,      // 0 / 1 / 2 = nk 4 / 6 / 8
    input  logic [$clog2(ROUND_KEY_WORDS)-3:0] rk_round, // round to use next
    input  logic [63:0]         blk_high,
    input  logic [63:0]         blk_low,
    output logic [127:0]        state_out
);
    import aes_pkg::*;

    localparam int AW = $clog2(ROUND_KEY_WORDS);
    localparam int RK_ENTRIES = (ROUND_KEY_WORDS + 3) / 4;

    // one entry per round: four key words, word 0 in the top bits
    logic [127:0] rk_mem [RK_ENTRIES];
    logic [127:0] rk_q;          // registered round key, four words
    logic [127:0] state_reg, state_next;

    // key expansion: sliding window of the last eight words
    logic [31:0]  win_reg [8];
    logic [AW-1:0] kx_idx_reg;
    logic [AW-1:0] kx_total;
    logic [7:0]   rc_reg;
    logic [3:0]   nk;
    logic [2:0]   pos_reg;   // i mod nk
    logic [31:0]  prev_w, far_w, t_w, new_w;

    assign nk = (nk_sel == 2'd0) ? 4'd4 : (nk_sel == 2'd1) ? 4'd6 : 4'd8;
    assign kx_total = (nk_sel == 2'd0) ? AW'(44) : (nk_sel == 2'd1) ? AW'(52) : AW'(60);
    assign stat.kx_done = (kx_idx_reg == kx_total);

    assign prev_w = win_reg[0];
    assign far_w  = win_reg[3'(nk - 4'd1)];

    always_comb begin
        t_w = prev_w;
        if (pos_reg == 3'd0) begin
            t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_reg, 24'd0};
        end else if (nk == 4'd8 && pos_reg == 3'd4) begin
            t_w = sub_word(prev_w);
        end
        new_w = far_w ^ t_w;
    end

    always_ff @(posedge aclk) begin
        if (cmd.kx_load) begin
            // window[0] newest: key word nk-1 sits at 0
            for (int i = 0; i < 8; i++) begin
                if (i < nk) begin
                    win_reg[i] <= key[255 - 32*(nk - 1 - i) -: 32];
                end else begin
                    win_reg[i] <= 32'd0;
                end
            end
            // key words beyond nk are overwritten by the expansion
            rk_mem[0] <= key[255:128];
            rk_mem[1] <= key[127:0];
            rc_reg  <= 8'h01;
            pos_reg <= 3'd0;
        end else if (cmd.kx_step) begin
            rk_mem[kx_idx_reg[AW-1:2]][127 - 32*kx_idx_reg[1:0] -: 32] <= new_w;
            win_reg[0] <= new_w;
            for (int i = 1; i < 8; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
            if (pos_reg == 3'd0) begin
                rc_reg <= xt(rc_reg);
            end
            pos_reg <= (pos_reg == 3'(nk - 4'd1)) ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kx_idx_reg <= '0;
        end else if (cmd.kx_load) begin
            kx_idx_reg <= AW'(nk);
        end else if (cmd.kx_step) begin
            kx_idx_reg <= kx_idx_reg + AW'(1);
        end
    end

    // round key read: one entry a cycle, registered
    always_ff @(posedge aclk) begin
        rk_q <= rk_mem[rk_round];
    end

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++) begin
            a[i]  = c[31 - 8*i -: 8];
            x2[i] = xt(a[i]);
            x4[i] = xt(x2[i]);
            x8[i] = xt(x4[i]);
            m2[i] = x2[i];
            m3[i] = x2[i] ^ a[i];
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        for (int i = 0; i < 4; i++) begin
            if (inv) begin
                r[31 - 8*i -: 8] = me[i] ^ mb[(i+1)%4] ^ md[(i+2)%4] ^ m9[(i+3)%4];
            end else begin
                r[31 - 8*i -: 8] = m2[i] ^ m3[(i+1)%4] ^ a[(i+2)%4] ^ a[(i+3)%4];
            end
        end
        return r;
    endfunction

    logic [7:0]   sb [16];
    logic [7:0]   sh [16];
    logic [127:0] shv, akv, mixed;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[i] = state_reg[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (cmd.dec) begin
                    sh[c*4 + r] = inv_sbox(sb[((c + 4 - r) % 4)*4 + r]);
                end else begin
                    sh[c*4 + r] = sbox(sb[((c + r) % 4)*4 + r]);
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            shv[127 - 8*i -: 8] = sh[i];
        end
        // encrypt: sub/shift, mix, add; decrypt: shift/sub, add, mix
        akv = shv ^ rk_q;
        for (int c = 0; c < 4; c++) begin
            if (cmd.dec) begin
                mixed[127 - 32*c -: 32] = mix_col(akv[127 - 32*c -: 32], 1'b1);
            end else begin
                mixed[127 - 32*c -: 32] = mix_col(shv[127 - 32*c -: 32], 1'b0)
                                          ^ rk_q[127 - 32*c -: 32];
            end
        end
        state_next = state_reg;
        if (cmd.load) begin
            state_next = {blk_high, blk_low} ^ rk_q;
        end else if (cmd.rnd) begin
            state_next = cmd.last ? akv : mixed;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
    end

    assign state_out = state_reg;

endmodule

### sv/aes_ctrl.sv
// ----------------------------------------------------------------------------
// aes_ctrl
// sequencer for key expansion, rounds and handshakes
// ----------------------------------------------------------------------------
module aes_ctrl #(
    parameter int ROUND_KEY_WORDS = aes_pkg::ROUND_KEY_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic                cfg_write,
    input  logic [1:0]          nk_sel,
    output aes_pkg::aes_cmd_t   cmd,
    input  aes_pkg::aes_stat_t  stat,
    output logic [$clog2(ROUND_KEY_WORDS)-3:0] rk_round,
    output logic                hold_in
);
    import aes_pkg::*;

    localparam int RW = $clog2(ROUND_KEY_WORDS) - 2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_KX   = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_RND  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic          sched_reg, sched_next;
    logic          dec_reg, dec_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic [RW-1:0] nr_reg;
    logic [3:0]    nr;

    assign nr = (nk_sel == 2'd0) ? 4'd10 : (nk_sel == 2'd1) ? 4'd12 : 4'd14;

    always_ff @(posedge aclk) begin
        nr_reg <= RW'(nr);
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign hold_in = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        sched_next = sched_reg;
        dec_next   = dec_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        cmd.dec    = dec_reg;
        rk_round   = rnd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dec_next = s_action;
                    if (!sched_reg) begin
                        cmd.kx_load = 1'b1;
                        state_next  = ST_KX;
                    end else begin
                        rnd_next   = s_action ? RW'(nr) : '0;
                        rk_round   = rnd_next;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_KX: begin
                if (stat.kx_done) begin
                    sched_next = 1'b1;
                    rnd_next   = dec_reg ? nr_reg : '0;
                    rk_round   = rnd_next;
                    state_next = ST_LOAD;
                end else begin
                    cmd.kx_step = 1'b1;
                end
            end
            ST_LOAD: begin
                // round key of rnd_reg now registered
                cmd.load   = 1'b1;
                rnd_next   = dec_reg ? rnd_reg - RW'(1) : rnd_reg + RW'(1);
                rk_round   = rnd_next;
                state_next = ST_RND;
            end
            ST_RND: begin
                cmd.rnd  = 1'b1;
                cmd.last = dec_reg ? (rnd_reg == '0) : (rnd_reg == nr_reg);
                if (cmd.last) begin
                    state_next = ST_OUT;
                end else begin
                    rnd_next = dec_reg ? rnd_reg - RW'(1) : rnd_reg + RW'(1);
                    rk_round = rnd_next;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_write) begin
            sched_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sched_reg <= 1'b0;
            dec_reg   <= 1'b0;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sched_reg <= sched_next;
            dec_reg   <= dec_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

### sv/aes_block_cipher_top.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_top
// iterative aes-128/192/256 ecb core, one round per cycle
// ----------------------------------------------------------------------------
// requests: one at a time; the next is taken only after the round loop, the
//   load and the result handoff, which waits for m_ready
// the first request after reset or a write to a known register adds a key
//   expansion, one schedule word a cycle
// reset: synchronous active low; key registers and key size clear to zero,
//   schedule marked stale, round key store left unwritten
module aes_block_cipher_top #(
    parameter int ROUND_KEY_WORDS = aes_pkg::ROUND_KEY_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import aes_pkg::*;

    localparam int RW = $clog2(ROUND_KEY_WORDS) - 2;

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [1:0]   ksize_reg;
    logic [1:0]   nk_sel;
    logic         cfg_write;
    logic [63:0]  blk_high_reg, blk_low_reg;
    logic         hold_in;
    aes_cmd_t     cmd;
    aes_stat_t    stat;
    logic [RW-1:0] rk_round;
    logic [127:0] state_out;

    assign cfg_ready = 1'b1;

    // only writes to a known register mark the schedule stale
    assign cfg_write = cfg_valid && (cfg_index <= REG_KSIZE);

    // key size three runs as 256; shrink to what the store can hold
    always_comb begin
        nk_sel = (ksize_reg == 2'd3) ? 2'd2 : ksize_reg;
        if (nk_sel == 2'd2 && ROUND_KEY_WORDS < 60) begin
            nk_sel = 2'd1;
        end
        if (nk_sel == 2'd1 && ROUND_KEY_WORDS < 52) begin
            nk_sel = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg  <= '0;
            key1_reg  <= '0;
            key2_reg  <= '0;
            key3_reg  <= '0;
            ksize_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY0:  key0_reg  <= cfg_data;
                REG_KEY1:  key1_reg  <= cfg_data;
                REG_KEY2:  key2_reg  <= cfg_data;
                REG_KEY3:  key3_reg  <= cfg_data;
                REG_KSIZE: ksize_reg <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // capture the block at acceptance
    always_ff @(posedge aclk) begin
        if (hold_in) begin
            blk_high_reg <= s_block_high;
            blk_low_reg  <= s_block_low;
        end
    end

    aes_ctrl #(
        .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_write (cfg_write),
        .nk_sel    (nk_sel),
        .cmd       (cmd),
        .stat      (stat),
        .rk_round  (rk_round),
        .hold_in   (hold_in)
    );

    aes_datapath #(
        .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .key       ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .nk_sel    (nk_sel),
        .rk_round  (rk_round),
        .blk_high  (blk_high_reg),
        .blk_low   (blk_low_reg),
        .state_out (state_out)
    );

    assign m_result_high = state_out[127:64];
    assign m_result_low  = state_out[63:0];

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the aes block cipher: an in-bench aes model
// predicts each result, a scoreboard checks results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class aes_scoreboard;
    logic [127:0] pending_blocks[$];
    int           error_count;

    function new();
        error_count = 0;
    endfunction

    function void note_request(logic [127:0] expected);
        pending_blocks.insert(pending_blocks.size(), expected);
    endfunction

    function void check_result(logic [63:0] hi, logic [63:0] lo);
        logic [127:0] exp_blk;
        if (pending_blocks.size() == 0) begin
            $error("result_high: expected none, actual %h (result_low %h)", hi, lo);
            error_count++;
            return;
        end
        exp_blk = pending_blocks.pop_front();
        if (exp_blk[127:64] !== hi) begin
            $error("result_high: expected %h, actual %h", exp_blk[127:64], hi);
            error_count++;
        end
        if (exp_blk[63:0] !== lo) begin
            $error("result_low: expected %h, actual %h", exp_blk[63:0], lo);
            error_count++;
        end
    endfunction
endclass

module tb_top;
    import aes_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 600;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [63:0] s_block_high;
    logic [63:0] s_block_low;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    aes_block_cipher_top DUT (.*);

    // model state: key registers, key size and the expanded schedule
    logic [63:0] key_regs[4];
    logic [1:0]  key_size_reg;
    logic [31:0] sched_words[ROUND_KEY_WORDS_DEF];
    bit          sched_valid;
    int          sched_rounds;

    // idle percentages of the sender and the receiver
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_recv;
    bit          hold_start = 1'b0;
    int          cycle_count = 0;

    aes_scoreboard scb;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // aes model
    // ------------------------------------------------------------------
    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = (a[7]) ? ({a[6:0], 1'b0} ^ 8'h1B) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [7:0] fwd_sub(logic [7:0] a);
        logic [7:0] t[256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    // inverse substitution by search over the forward table
    function automatic logic [7:0] rev_sub(logic [7:0] b);
        for (int k = 0; k < 256; k++)
            if (fwd_sub(k[7:0]) == b) return k[7:0];
        return 8'h00;
    endfunction

    function automatic logic [31:0] sub4(logic [31:0] w);
        return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
    endfunction

    // fips-197 key expansion into the model's schedule
    task automatic build_schedule();
        logic [31:0] kw[8];
        logic [31:0] t;
        logic [7:0]  rc;
        int          nr;
        int          nk;
        nr = 10 + 2 * ((key_size_reg > 2'd2) ? 2 : int'(key_size_reg));
        while (nr > 10 && 4 * (nr + 1) > ROUND_KEY_WORDS_DEF) nr -= 2;
        nk = nr - 6;
        rc = 8'h01;
        for (int j = 0; j < 4; j++) begin
            kw[2*j]   = key_regs[j][63:32];
            kw[2*j+1] = key_regs[j][31:0];
        end
        for (int i = 0; i < 4 * (nr + 1); i++) begin
            if (i < nk) begin
                sched_words[i] = kw[i];
            end else begin
                t = sched_words[i-1];
                if (i % nk == 0) begin
                    t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = (rc[7]) ? ({rc[6:0], 1'b0} ^ 8'h1B) : {rc[6:0], 1'b0};
                end else if (nk > 6 && i % nk == 4) begin
                    t = sub4(t);
                end
                sched_words[i] = sched_words[i-nk] ^ t;
            end
        end
        sched_rounds = nr;
        sched_valid  = 1'b1;
    endtask

    function automatic void add_round_key(ref logic [7:0] st[16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                st[c*4+r] ^= sched_words[rnd*4+c][31-8*r -: 8];
    endfunction

    function automatic void shift_state(ref logic [7:0] st[16], input bit inverse);
        logic [7:0] t[16];
        t = st;
        for (int r = 1; r < 4; r++)
            for (int c = 0; c < 4; c++)
                st[c*4+r] = t[(inverse ? (c + 4 - r) % 4 : (c + r) % 4) * 4 + r];
    endfunction

    function automatic void mix_state(ref logic [7:0] st[16], input bit inverse);
        logic [7:0] a[4];
        logic [7:0] m[4];
        if (inverse) begin
            m[0] = 8'h0E; m[1] = 8'h0B; m[2] = 8'h0D; m[3] = 8'h09;
        end else begin
            m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = st[c*4+r];
            for (int r = 0; r < 4; r++)
                st[c*4+r] = gmul(m[0], a[r]) ^ gmul(m[1], a[(r+1)%4]) ^
                            gmul(m[2], a[(r+2)%4]) ^ gmul(m[3], a[(r+3)%4]);
        end
    endfunction

    // expected cipher output of one request
    task automatic cipher_block(input bit dec, input logic [127:0] blk,
                                output logic [127:0] res);
        logic [7:0] st[16];
        if (!sched_valid) build_schedule();
        for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
        if (!dec) begin
            add_round_key(st, 0);
            for (int rnd = 1; rnd <= sched_rounds; rnd++) begin
                for (int i = 0; i < 16; i++) st[i] = fwd_sub(st[i]);
                shift_state(st, 1'b0);
                if (rnd < sched_rounds) mix_state(st, 1'b0);
                add_round_key(st, rnd);
            end
        end else begin
            add_round_key(st, sched_rounds);
            for (int rnd = sched_rounds - 1; rnd >= 0; rnd--) begin
                shift_state(st, 1'b1);
                for (int i = 0; i < 16; i++) st[i] = rev_sub(st[i]);
                add_round_key(st, rnd);
                if (rnd > 0) mix_state(st, 1'b1);
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one register write; only called while the core is idle
    task automatic write_register(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                key_regs[idx[1:0]] = val;
                sched_valid = 1'b0;
            end
            REG_KSIZE: begin
                key_size_reg = val[1:0];
                sched_valid = 1'b0;
            end
            default: ;  // out of range index leaves the schedule alone
        endcase
        @(posedge aclk);
    endtask

    task automatic load_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] ks);
        write_register(REG_KEY0, k0);
        write_register(REG_KEY1, k1);
        write_register(REG_KEY2, k2);
        write_register(REG_KEY3, k3);
        write_register(REG_KSIZE, {62'd0, ks});
    endtask

    // one request: hold valid until accepted, then predict its result
    task automatic send_request(input bit dec, input logic [63:0] hi, lo);
        logic [127:0] exp_blk;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= dec;
        s_block_high <= hi;
        s_block_low  <= lo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cipher_block(dec, {hi, lo}, exp_blk);
        scb.note_request(exp_blk);
    endtask

    // wait for all results, then let the core settle before the next write
    task automatic drain();
        s_valid <= 1'b0;
        while (scb.pending_blocks.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random field value biased toward all zeros and all ones
    function automatic logic [63:0] pick64();
        case ($urandom_range(9))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall plus a long hold-off window
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) scb.check_result(m_result_high, m_result_low);
            m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing
    initial begin
        hold_recv = 1'b0;
        wait (hold_start);
        @(posedge aclk);
        hold_recv <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_recv <= 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[aes_block_cipher_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_items;
        scb           = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = 1'b0;
        s_block_high  = '0;
        s_block_low   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int j = 0; j < 4; j++) key_regs[j] = '0;
        key_size_reg  = 2'd0;
        sched_valid   = 1'b0;
        sched_rounds  = 10;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset key, both actions, field extremes
        send_request(1'b0, 64'h0, 64'h0);
        send_request(1'b1, 64'h0, 64'h0);
        send_request(1'b0, '1, '1);
        drain();
        // fips-197 example vectors for each key size
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f, 2'd0);
        send_request(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_request(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        drain();
        write_register(REG_KSIZE, 64'd1);
        send_request(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_request(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        drain();
        write_register(REG_KSIZE, 64'd2);
        send_request(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_request(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();
        // key size three acts as 256 bit
        write_register(REG_KSIZE, 64'd3);
        send_request(1'b0, '1, 64'h0);
        send_request(1'b1, 64'h0, '1);
        drain();
        // out of range index must not disturb the schedule
        write_register(3'd5, '1);
        write_register(3'd7, 64'h0);
        send_request(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();
        // all ones key, unused words differ per size
        load_key('1, '1, 64'h0, '1, 2'd0);
        send_request(1'b0, '1, '1);
        send_request(1'b1, '1, '1);
        drain();

        // random phases: idle profile rotates, key changes between phases
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 63; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 63; end
                default: begin send_idle_pct = 21; recv_idle_pct = 21; end
            endcase
            load_key(pick64(), pick64(), pick64(), pick64(),
                     (ph < 3) ? ph[1:0] : 2'($urandom_range(3)));
            if ($urandom_range(3) == 0) write_register(3'($urandom_range(7, 5)), rand64());
            if (ph == 4) hold_start = 1'b1;
            phase_items = 103;
            for (int n = 0; n < phase_items; n++)
                send_request(1'($urandom_range(1)), pick64(), pick64());
            drain();
        end

        if (scb.error_count == 0 && scb.pending_blocks.size() == 0)
            $display("[aes_block_cipher_top] OK");
        else
            $display("[aes_block_cipher_top] ERROR");
        $finish;
    end
endmodule
